[rtl/cqs_pkg.sv]
// Shared constants, codes and index helpers for the circular queue with search.
package cqs_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CAP_W  = 8;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	// Capacity register reset value, also used when the register holds zero.
	localparam int DEFAULT_CAP = 100;
	localparam int EFF_DEFAULT_CAP = (DEFAULT_CAP > DEPTH) ? DEPTH : DEFAULT_CAP;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_BITS  = MODE_W + DATA_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + 1 + DATA_W + DATA_W + 1 + 1 + CAP_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Bit positions of the result fields inside the output tdata.
	localparam int O_STATUS = 0;
	localparam int O_FOUND  = O_STATUS + STAT_W;
	localparam int O_HEAD   = O_FOUND + 1;
	localparam int O_TAIL   = O_HEAD + DATA_W;
	localparam int O_EMPTY  = O_TAIL + DATA_W;
	localparam int O_FULL   = O_EMPTY + 1;
	localparam int O_COUNT  = O_FULL + 1;

	localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Capacity actually in use: zero selects the default, large values saturate.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(EFF_DEFAULT_CAP);
		end else if (int'(c) > DEPTH) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

	// Advance a slot index, wrapping at the capacity in use.
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
	                                              input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] inc;
		inc = CNT_W'(i) + CNT_W'(1);
		return (inc >= cap) ? '0 : IDX_W'(inc);
	endfunction

endpackage

[rtl/cqs_slot_ram.sv]
// Slot storage: one write port and one registered read port.
module cqs_slot_ram #(
	parameter int DEPTH  = 128,
	parameter int DATA_W = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/circular_queue_with_search_unit.sv]
// Top level of the circular queue with search: control, index state and result register.
//
//  Channel  Direction  Signals                      Moves
//  s_*      in         s_tvalid s_tready s_tdata    one operation per transfer
//  m_*      out        m_tvalid m_tready m_tdata    one result per operation
//  cfg_*    in         cfg_valid cfg_ready cfg_data capacity register write
//
// Enqueue, rejected operations, a search of an empty queue and the unused mode go through
// S_DONE to the result register; a dequeue first passes S_DEQ_RD to read the new head
// value back from the slot RAM. A search walks the held entries through the single RAM
// read port, one per cycle, until the first match or the last entry. A new operation is
// taken while a finished result still waits on m_*; the unit stalls only when a second
// result is ready before the first has been taken. Reset needs no clearing pass: slots
// are only read after they are written. A dequeue that empties the queue may read one
// unwritten, but m_* never shows it. A capacity write empties the queue and is taken only
// in the idle state, while no operation transfer is offered and no result waits on m_*.
module circular_queue_with_search_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// mode [1:0], data_value [33:2], zero padding above
	input  logic [cqs_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status [1:0], found [2], head_value [34:3], tail_value [66:35],
	// is_empty [67], is_full [68], entry_count [76:69], zero padding above
	output logic [cqs_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cqs_pkg::CAP_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DEQ_RD = 4'b0010,
		S_SEARCH = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [cqs_pkg::CNT_W-1:0]       cap_q;
	logic [cqs_pkg::IDX_W-1:0]       head_q;
	logic [cqs_pkg::IDX_W-1:0]       tail_q;
	logic [cqs_pkg::CNT_W-1:0]       count_q;

	// Cached copies of the head and tail slots, valid while the queue holds entries.
	logic [cqs_pkg::DATA_W-1:0]      head_val_q;
	logic [cqs_pkg::DATA_W-1:0]      tail_val_q;

	cqs_pkg::status_t                status_q;
	logic                            found_q;
	logic [cqs_pkg::DATA_W-1:0]      key_q;
	logic [cqs_pkg::IDX_W-1:0]       srch_ptr_q;
	logic [cqs_pkg::CNT_W-1:0]       srch_left_q;
	logic                            rd_pend_s1;

	logic                            m_tvalid_q;
	logic [cqs_pkg::OUT_W-1:0]       m_tdata_q;

	logic [cqs_pkg::MODE_W-1:0]      in_mode;
	logic [cqs_pkg::DATA_W-1:0]      in_value;
	logic                            in_xfer;
	logic                            cfg_xfer;
	logic [cqs_pkg::IDX_W-1:0]       tail_next;
	logic [cqs_pkg::IDX_W-1:0]       head_next;
	logic [cqs_pkg::CNT_W-1:0]       cfg_cap;
	logic                            out_free;
	logic                            q_empty;
	logic [cqs_pkg::DATA_W-1:0]      head_out;
	logic [cqs_pkg::DATA_W-1:0]      tail_out;

	logic                            ram_wr_en;
	logic                            ram_rd_en;
	logic [cqs_pkg::IDX_W-1:0]       ram_rd_addr;
	logic [cqs_pkg::DATA_W-1:0]      ram_rd_data;

	assign in_mode   = s_tdata[cqs_pkg::MODE_W-1:0];
	assign in_value  = s_tdata[cqs_pkg::MODE_W +: cqs_pkg::DATA_W];
	assign s_tready  = (state_q == S_IDLE);
	// An offered operation takes precedence, and a write waits until the last result
	// has been taken, so the capacity never changes under a transfer in flight.
	assign cfg_ready = (state_q == S_IDLE) && !s_tvalid && !m_tvalid_q;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign tail_next = cqs_pkg::next_idx(tail_q, cap_q);
	assign head_next = cqs_pkg::next_idx(head_q, cap_q);
	assign cfg_cap   = cqs_pkg::eff_cap(cfg_data);
	assign out_free  = !m_tvalid_q || m_tready;
	assign q_empty   = (count_q == '0);
	assign head_out  = q_empty ? '0 : head_val_q;
	assign tail_out  = q_empty ? '0 : tail_val_q;

	// Slot RAM control. Enqueue writes at the advanced tail; dequeue reads the new head;
	// search streams reads from head onward.
	assign ram_wr_en = in_xfer && (in_mode == cqs_pkg::MODE_ENQ) && (count_q < cap_q);

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = srch_ptr_q;
		if (in_xfer && (in_mode == cqs_pkg::MODE_DEQ) && !q_empty) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = head_next;
		end else if ((state_q == S_SEARCH) && (srch_left_q != '0) && !found_q) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = srch_ptr_q;
		end
	end

	cqs_slot_ram #(
		.DEPTH  (cqs_pkg::DEPTH),
		.DATA_W (cqs_pkg::DATA_W)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (tail_next),
		.wr_data (in_value),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= cqs_pkg::CNT_W'(cqs_pkg::EFF_DEFAULT_CAP);
			head_q      <= '0;
			tail_q      <= cqs_pkg::IDX_W'(cqs_pkg::EFF_DEFAULT_CAP - 1);
			count_q     <= '0;
			status_q    <= cqs_pkg::STAT_DONE;
			found_q     <= 1'b0;
			srch_left_q <= '0;
			rd_pend_s1  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// A new result replaces a taken one in the same cycle.
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						found_q <= 1'b0;
						case (in_mode)
							cqs_pkg::MODE_ENQ: begin
								state_q <= S_DONE;
								if (count_q >= cap_q) begin
									status_q <= cqs_pkg::STAT_FULL;
								end else begin
									status_q   <= cqs_pkg::STAT_DONE;
									tail_q     <= tail_next;
									count_q    <= count_q + 1'b1;
									tail_val_q <= in_value;
									if (q_empty) begin
										head_val_q <= in_value;
									end
								end
							end
							cqs_pkg::MODE_DEQ: begin
								if (q_empty) begin
									status_q <= cqs_pkg::STAT_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= cqs_pkg::STAT_DONE;
									head_q   <= head_next;
									count_q  <= count_q - 1'b1;
									state_q  <= S_DEQ_RD;
								end
							end
							cqs_pkg::MODE_SEARCH: begin
								status_q <= cqs_pkg::STAT_DONE;
								key_q    <= in_value;
								if (!q_empty) begin
									srch_ptr_q  <= head_q;
									srch_left_q <= count_q;
									rd_pend_s1  <= 1'b0;
									state_q     <= S_SEARCH;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								status_q <= cqs_pkg::STAT_DONE;
								state_q  <= S_DONE;
							end
						endcase
					end else if (cfg_xfer) begin
						cap_q   <= cfg_cap;
						head_q  <= '0;
						tail_q  <= cqs_pkg::IDX_W'(cfg_cap - 1'b1);
						count_q <= '0;
					end
				end

				S_DEQ_RD: begin
					// Read data of the new head slot arrives now.
					head_val_q <= ram_rd_data;
					state_q    <= S_DONE;
				end

				S_SEARCH: begin
					if (ram_rd_en) begin
						srch_ptr_q  <= cqs_pkg::next_idx(srch_ptr_q, cap_q);
						srch_left_q <= srch_left_q - 1'b1;
					end
					if (rd_pend_s1 && (ram_rd_data == key_q)) begin
						found_q    <= 1'b1;
						rd_pend_s1 <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						rd_pend_s1 <= ram_rd_en;
						if ((srch_left_q == '0) && !rd_pend_s1) begin
							state_q <= S_DONE;
						end
					end
				end

				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; the head and tail fields read as zero on an empty queue.
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= {{(cqs_pkg::OUT_W - cqs_pkg::OUT_BITS){1'b0}},
			              cqs_pkg::CAP_W'(count_q), (count_q == cap_q), q_empty,
			              tail_out, head_out, found_q, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/cqs_checker.sv]
// Port-level checks on the result stream of the circular queue with search.
module cqs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cqs_pkg::OUT_W-1:0] m_tdata
);

	logic [cqs_pkg::CAP_W-1:0]  r_count;
	logic [cqs_pkg::STAT_W-1:0] r_status;
	logic                       r_found;
	logic                       r_empty;
	logic                       r_full;
	logic [cqs_pkg::DATA_W-1:0] r_head;
	logic [cqs_pkg::DATA_W-1:0] r_tail;

	assign r_count  = m_tdata[cqs_pkg::O_COUNT +: cqs_pkg::CAP_W];
	assign r_status = m_tdata[cqs_pkg::O_STATUS +: cqs_pkg::STAT_W];
	assign r_found  = m_tdata[cqs_pkg::O_FOUND];
	assign r_empty  = m_tdata[cqs_pkg::O_EMPTY];
	assign r_full   = m_tdata[cqs_pkg::O_FULL];
	assign r_head   = m_tdata[cqs_pkg::O_HEAD +: cqs_pkg::DATA_W];
	assign r_tail   = m_tdata[cqs_pkg::O_TAIL +: cqs_pkg::DATA_W];

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The empty flag agrees with the count, and an empty queue shows zero values.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r_empty == (r_count == '0)) &&
		             (!r_empty || ((r_head == '0) && (r_tail == '0))))
		else $error("empty flag, count or values disagree");

	// A match is only reported by a completed operation, never with a rejection.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_found |-> (r_status == cqs_pkg::STAT_DONE) && !r_empty)
		else $error("found set on a rejected or empty result");

	// Rejection codes match the queue state they report, and no other code appears.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((r_status != cqs_pkg::STAT_FULL) || r_full) &&
		             ((r_status != cqs_pkg::STAT_EMPTY) || r_empty) &&
		             ((r_status == cqs_pkg::STAT_DONE) ||
		              (r_status == cqs_pkg::STAT_FULL) ||
		              (r_status == cqs_pkg::STAT_EMPTY)))
		else $error("status code inconsistent with queue state");

	// The count never exceeds the storage depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(r_count) <= cqs_pkg::DEPTH))
		else $error("entry count above depth");

endmodule

bind circular_queue_with_search_unit cqs_checker u_cqs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the circular queue with search unit.
`timescale 1ns / 100ps

module testbench;
	import cqs_pkg::*;

	// Mode code that the unit must ignore.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// Cycles without any transfer before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// Cycles to keep watching the result channel once nothing is pending.
	localparam int DRAIN_CYCLES = 12;
	localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;

	// What the unit reports about the queue after one operation.
	typedef struct {
		status_t           status;
		logic              found;
		logic [DATA_W-1:0] head_value;
		logic [DATA_W-1:0] tail_value;
		logic              is_empty;
		logic              is_full;
		logic [CAP_W-1:0]  entry_count;
	} queue_view_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// mode [1:0], data_value [33:2], zero padding above
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// status [1:0], found [2], head_value [34:3], tail_value [66:35],
	// is_empty [67], is_full [68], entry_count [76:69], zero padding above
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;

	// Shadow copy of the queue, updated when each operation transfer is accepted.
	logic [DATA_W-1:0] slot_copy [DEPTH];
	int                head_pos;
	int                tail_pos;
	int                held;
	logic [CAP_W-1:0]  capacity_reg;

	// Predicted queue views, oldest first, waiting for their result transfers.
	queue_view_t       predicted_views [$];

	int                err_count;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                stall_cycles;

	circular_queue_with_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A capacity of zero falls back to the default, and anything past the
	// storage depth is clipped to it.
	function automatic int slots_in_use(logic [CAP_W-1:0] c);
		int n;
		n = (c == '0) ? DEFAULT_CAP : int'(c);
		if (n > DEPTH) begin
			n = DEPTH;
		end
		return n;
	endfunction

	// Slot indexes wrap at the capacity in use, not at the storage depth.
	function automatic int step_index(int i);
		int n;
		n = i + 1;
		return (n >= slots_in_use(capacity_reg)) ? 0 : n;
	endfunction

	// The tail sits one slot behind the head so the first enqueue lands in slot zero.
	function automatic void empty_queue();
		head_pos = 0;
		tail_pos = slots_in_use(capacity_reg) - 1;
		held = 0;
	endfunction

	// Value of the k-th held entry counted from the head.
	function automatic logic [DATA_W-1:0] held_entry(int k);
		return slot_copy[(head_pos + k) % slots_in_use(capacity_reg)];
	endfunction

	// Applies one operation to the shadow queue and returns the view the unit should report.
	function automatic queue_view_t apply_op(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
		queue_view_t v;
		int cap;
		int pos;
		int k;
		cap = slots_in_use(capacity_reg);
		v.status = STAT_DONE;
		v.found = 1'b0;
		case (mode)
			MODE_ENQ: begin
				if (held >= cap) begin
					v.status = STAT_FULL;
				end else begin
					tail_pos = step_index(tail_pos);
					slot_copy[tail_pos] = value;
					held++;
				end
			end
			MODE_DEQ: begin
				if (held == 0) begin
					v.status = STAT_EMPTY;
				end else begin
					head_pos = step_index(head_pos);
					held--;
				end
			end
			MODE_SEARCH: begin
				// Only held entries are compared, so an empty queue never matches
				// whatever is left in the stale slots.
				pos = head_pos;
				for (k = 0; k < held; k++) begin
					if (slot_copy[pos] == value) begin
						v.found = 1'b1;
					end
					pos = step_index(pos);
				end
			end
			default: begin
			end
		endcase
		v.head_value = (held == 0) ? '0 : slot_copy[head_pos];
		v.tail_value = (held == 0) ? '0 : slot_copy[tail_pos];
		v.is_empty = (held == 0);
		v.is_full = (held == cap);
		v.entry_count = CAP_W'(held);
		return v;
	endfunction

	// Mix of wide random words, a small pool that repeats, and values already held.
	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(3))
			0, 1: v = $urandom;
			2: v = DATA_W'($urandom_range(15)) - DATA_W'(8);
			default: v = (held > 0) ? held_entry($urandom_range(held - 1)) : $urandom;
		endcase
		return v;
	endfunction

	// Search for a held value most of the time, so hits land anywhere in the queue.
	function automatic logic [DATA_W-1:0] search_value();
		return (held > 0 && $urandom_range(1) == 1) ? held_entry($urandom_range(held - 1))
		                                            : pick_value();
	endfunction

	// Sends one operation. Called and returns at a falling edge; tvalid stays high
	// between back-to-back operations.
	task automatic issue_op(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - IN_BITS){1'b0}}, value, mode};
		do @(posedge clk); while (!s_tready);
		predicted_views.push_back(apply_op(mode, value));
		@(negedge clk);
	endtask

	// Capacity writes go in only once every pending result has been taken.
	task automatic set_capacity(logic [CAP_W-1:0] c);
		s_tvalid <= 1'b0;
		while (predicted_views.size() != 0) begin
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		capacity_reg = c;
		empty_queue();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
	                                    logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
			err_count++;
		end
	endfunction

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		queue_view_t want;
		logic [OUT_W-1:0] d;
		if (arst_n && m_tvalid && m_tready) begin
			d = m_tdata;
			if (predicted_views.size() == 0) begin
				$error("result transfer with no operation pending");
				err_count++;
			end else begin
				want = predicted_views.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(d[O_STATUS +: STAT_W]));
				check_field("found", DATA_W'(want.found), DATA_W'(d[O_FOUND]));
				check_field("head_value", want.head_value, d[O_HEAD +: DATA_W]);
				check_field("tail_value", want.tail_value, d[O_TAIL +: DATA_W]);
				check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(d[O_EMPTY]));
				check_field("is_full", DATA_W'(want.is_full), DATA_W'(d[O_FULL]));
				check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(d[O_COUNT +: CAP_W]));
			end
		end
	end

	// The result side stalls at random according to the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Edge cases at the reset capacity: empty queue rejections, the ignored mode,
	// the extreme data values, hits at head and tail, and a search of an emptied
	// queue whose stale slots still hold the value looked for.
	task automatic test_directed();
		issue_op(MODE_SEARCH, '0);
		issue_op(MODE_DEQ, '0);
		issue_op(MODE_UNUSED, MOST_POSITIVE);
		issue_op(MODE_ENQ, MOST_NEGATIVE);
		issue_op(MODE_ENQ, MOST_POSITIVE);
		issue_op(MODE_ENQ, '0);
		issue_op(MODE_ENQ, '1);
		issue_op(MODE_SEARCH, MOST_NEGATIVE);
		issue_op(MODE_SEARCH, '1);
		issue_op(MODE_SEARCH, 32'd12345);
		issue_op(MODE_UNUSED, '1);
		issue_op(MODE_DEQ, MOST_POSITIVE);
		issue_op(MODE_SEARCH, MOST_NEGATIVE);
		repeat (3) issue_op(MODE_DEQ, '0);
		issue_op(MODE_DEQ, '0);
		issue_op(MODE_SEARCH, '1);
		issue_op(MODE_SEARCH, '0);
	endtask

	// Capacity extremes: a single slot, an oversized value that saturates at the
	// storage depth (filled, overfilled and wrapped), and zero selecting the default.
	task automatic test_capacity_limits();
		set_capacity(8'd1);
		issue_op(MODE_ENQ, 32'hA5A5_5A5A);
		issue_op(MODE_ENQ, 32'h1234_5678);
		issue_op(MODE_SEARCH, 32'hA5A5_5A5A);
		issue_op(MODE_SEARCH, 32'h1234_5678);
		issue_op(MODE_DEQ, '0);
		issue_op(MODE_DEQ, '0);
		issue_op(MODE_ENQ, 32'h5A5A_A5A5);
		issue_op(MODE_SEARCH, 32'h5A5A_A5A5);
		issue_op(MODE_DEQ, '0);

		set_capacity(8'd255);
		repeat (DEPTH + 1) issue_op(MODE_ENQ, pick_value());
		issue_op(MODE_SEARCH, held_entry(0));
		issue_op(MODE_SEARCH, held_entry(held - 1));
		issue_op(MODE_SEARCH, $urandom);
		repeat (40) issue_op(MODE_DEQ, '0);
		repeat (41) issue_op(MODE_ENQ, pick_value());
		issue_op(MODE_SEARCH, held_entry(held - 1));

		// The queue is not empty here, so this write also checks that it is cleared.
		set_capacity(8'd0);
		repeat (3) issue_op(MODE_ENQ, pick_value());
		issue_op(MODE_SEARCH, search_value());
		issue_op(MODE_DEQ, '0);
	endtask

	// Random segments, each at a fresh capacity: the first half of a segment mostly
	// enqueues and the second half moves part of those to dequeues, so small capacities
	// wrap and hit both full and empty many times.
	task automatic test_random(int n_ops);
		int done;
		int seg;
		int len;
		int roll;
		logic [CAP_W-1:0] c;
		done = 0;
		while (done < n_ops) begin
			case ($urandom_range(7))
				0: c = 8'd1;
				1: c = 8'd2;
				2: c = CAP_W'($urandom_range(3, 8));
				3: c = CAP_W'($urandom_range(1, 32));
				4: c = CAP_W'($urandom_range(1, DEPTH));
				5: c = 8'd0;
				6: c = CAP_W'(DEPTH);
				default: c = CAP_W'($urandom_range(DEPTH + 1, 255));
			endcase
			set_capacity(c);
			len = $urandom_range(30, 80);
			for (seg = 0; seg < len && done < n_ops; seg++) begin
				roll = $urandom_range(99);
				if (seg >= len / 2) begin
					roll = (roll < 55) ? roll + 15 : roll;
				end
				if (roll < 55) begin
					issue_op(MODE_ENQ, pick_value());
				end else if (roll < 70) begin
					issue_op(MODE_DEQ, pick_value());
				end else if (roll < 95) begin
					issue_op(MODE_SEARCH, search_value());
				end else begin
					issue_op(MODE_UNUSED, pick_value());
				end
				done++;
			end
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		err_count = 0;
		stall_cycles = 0;
		send_idle_pct = 8;
		recv_idle_pct = 84;
		capacity_reg = CAP_W'(DEFAULT_CAP);
		empty_queue();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_capacity_limits();

		send_idle_pct = 84;
		recv_idle_pct = 8;
		test_random(240);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(240);

		// Let every pending result come out, then watch for strays.
		s_tvalid <= 1'b0;
		while (predicted_views.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/cqs_pkg.sv
rtl/cqs_slot_ram.sv
rtl/circular_queue_with_search_unit.sv
rtl/cqs_checker.sv
tb/sv/testbench.sv
